[rtl/pulse_position_weight_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Pulse position weight decoder assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PULSE_POSITION_WEIGHT_DECODER_CORE_MACROS_SVH
`define PULSE_POSITION_WEIGHT_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PPWD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPWD_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define PPWD_ASSERT_IMPLY(name, ante, cons)
`define PPWD_ASSERT_NEVER(name, cond)
`endif

`endif

[rtl/ppwd_pkg.sv]
// ----------------------------------------------------------------------------
// ppwd_pkg
// Shared constants, register codes and control types of the decoder.
// ----------------------------------------------------------------------------
package ppwd_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 4;
  localparam int TIME_MAX_W    = 64;

  localparam int EDGE_W   = 48;
  localparam int MULT_W   = 16;
  localparam int TICK_W   = 16;
  localparam int CODE_W   = 12;
  localparam int DIGIT_W  = 6;
  localparam int SUM_W    = 48;
  localparam int PROD_W   = CODE_W + MULT_W;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 80;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_TICK   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NESTED = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TWIN   = 2'd3;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd1000;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] tick_period;
    logic [EDGE_W-1:0] start_time;
    logic              nested_mode;
    logic              twin_mode;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic offs;
    logic start;
    logic read;
    logic digit;
    logic mul;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic emit;
    logic out_busy;
  } stat_t;

endpackage

[rtl/ppwd_div.sv]
// ----------------------------------------------------------------------------
// ppwd_div
// Restoring divider, two quotient bits per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
`include "pulse_position_weight_decoder_core_macros.svh"

module ppwd_div #(
  parameter int DIV_W = 52
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [ppwd_pkg::TICK_W-1:0] divisor,
  output logic [DIV_W-1:0]          quot,
  output logic [ppwd_pkg::TICK_W-1:0] rem,
  output logic                      done
);

  localparam int TW    = ppwd_pkg::TICK_W;
  localparam int ITER  = DIV_W / 2;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [DIV_W-1:0] shreg;
  logic [TW-1:0]    remr;
  logic [TW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [TW:0]   trial_a;
  logic [TW:0]   trial_b;
  logic          ge_a;
  logic          ge_b;
  logic [TW-1:0] rem_a;
  logic [TW-1:0] rem_b;

  always_comb begin
    trial_a = {remr, shreg[DIV_W-1]};
    ge_a    = trial_a >= {1'b0, dvs};
    rem_a   = ge_a ? TW'(trial_a - {1'b0, dvs}) : TW'(trial_a);
    trial_b = {rem_a, shreg[DIV_W-2]};
    ge_b    = trial_b >= {1'b0, dvs};
    rem_b   = ge_b ? TW'(trial_b - {1'b0, dvs}) : TW'(trial_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ITER);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      remr  <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DIV_W-3:0], ge_a, ge_b};
      remr  <= rem_b;
    end
  end

  assign quot = shreg;
  assign rem  = remr;

  `PPWD_ASSERT_NEVER(a_div_restart_busy, start && busy)

endmodule

[rtl/ppwd_datapath.sv]
// ----------------------------------------------------------------------------
// ppwd_datapath
// Slot offset, dial reading, twin averaging, digit joining and saturating sum.
// ----------------------------------------------------------------------------
`include "pulse_position_weight_decoder_core_macros.svh"

module ppwd_datapath #(
  parameter int TIME_BITS = ppwd_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = ppwd_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ppwd_pkg::cfg_t                   cfg,
  input  ppwd_pkg::cmd_t                   cmd,
  output ppwd_pkg::stat_t                  stat,
  input  logic [ppwd_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ppwd_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int TB     = TIME_BITS;
  localparam int F      = FRAC_BITS;
  localparam int TW     = ppwd_pkg::TICK_W;
  localparam int CW     = ppwd_pkg::CODE_W;
  localparam int GW     = ppwd_pkg::DIGIT_W;
  localparam int MW     = ppwd_pkg::MULT_W;
  localparam int SW     = ppwd_pkg::SUM_W;
  localparam int PW     = ppwd_pkg::PROD_W;
  localparam int EW     = ppwd_pkg::EDGE_W;
  localparam int XW     = ppwd_pkg::TIME_MAX_W;
  localparam int RW     = CW + F;
  localparam int NW     = GW + F;
  localparam int DW     = TB + F;
  localparam int DWE    = DW + (DW % 2);
  localparam int VW     = RW + 3;
  localparam int PAD_W  = ppwd_pkg::M_TDATA_W - (3 * CW / 1 - CW + 1 + SW);

  localparam logic [RW-1:0] NEST_MASK  = RW'((64'd1 << NW) - 64'd1);
  localparam logic [RW-1:0] HDIAL_FLAT = RW'(1) << (CW - 1 + F);
  localparam logic [RW-1:0] HDIAL_NEST = RW'(1) << (GW - 1 + F);
  localparam logic [RW:0]   HALF_TICK  = (RW + 1)'((64'd1 << F) >> 1);
  localparam logic [VW-1:0] BIG_FLAT   = VW'(1) << RW;
  localparam logic [VW-1:0] BIG_NEST   = VW'(1) << NW;
  localparam logic [VW-1:0] ONE_TICK   = VW'(1) << F;
  localparam logic [VW-1:0] LIM        = VW'(2) << F;

  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW - 1){1'b0}}};

  logic [TB-1:0]        edge_t;
  logic signed [MW-1:0] mult;
  logic [TB-1:0]        t_off;
  logic [TB-1:0]        slot_offset;
  logic                 neg;
  logic [RW-1:0]        rd;
  logic [1:0]           edge_phase;
  logic [GW-1:0]        partial;
  logic [RW-1:0]        first_rd;
  logic                 pair_flag;
  logic [CW-1:0]        code_r;
  logic                 flag_r;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] run_sum;

  logic [CW-1:0]        out_code;
  logic                 out_flag;
  logic [SW-1:0]        out_sum;

  logic [XW-1:0] edge_x;
  logic [XW-1:0] start_x;
  logic [TB-1:0] edge_in;
  logic [TB-1:0] start_tb;
  logic [TW-1:0] tick_eff;
  logic [TB-1:0] slot_inc;
  logic [TB-1:0] mag;
  logic [DWE-1:0] dividend;
  logic [DWE-1:0] quot;
  logic [TW-1:0]  rem;
  logic           div_done;
  logic [RW-1:0]  q_lo;

  logic [RW-1:0]        big_mask;
  logic [RW-1:0]        r1;
  logic [RW-1:0]        r2;
  logic [RW-1:0]        diff;
  logic                 diff_hi;
  logic signed [VW-1:0] d_s;
  logic signed [VW-1:0] v_s;
  logic                 bad;
  logic [RW:0]          sum_h;
  logic [CW-1:0]        digit_tw;
  logic [CW-1:0]        digit_pl;
  logic [CW-1:0]        digit_raw;
  logic [CW-1:0]        digit;
  logic [CW-1:0]        code_next;

  logic [1:0] phase_mask;
  logic [1:0] phase;
  logic       dd;
  logic       twin_first;
  logic       nest_first;
  logic       emit;

  logic signed [SW:0]   sum_full;
  logic signed [SW-1:0] sum_sat;

  assign edge_x   = {{(XW - EW){1'b0}}, s_tdata[EW-1:0]};
  assign start_x  = {{(XW - EW){1'b0}}, cfg.start_time};
  assign edge_in  = edge_x[TB-1:0];
  assign start_tb = start_x[TB-1:0];
  assign tick_eff = (cfg.tick_period == '0) ? TW'(1) : cfg.tick_period;
  assign slot_inc = cfg.nested_mode ? (TB'(tick_eff) << GW) : (TB'(tick_eff) << CW);
  assign mag      = t_off[TB-1] ? TB'(-t_off) : t_off;
  assign dividend = DWE'(mag) << F;
  assign q_lo     = quot[RW-1:0];

  ppwd_div #(
    .DIV_W (DWE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (dividend),
    .divisor  (tick_eff),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  // twin pair: rotate the copy back, average along the short way round
  always_comb begin
    big_mask = cfg.nested_mode ? NEST_MASK : '1;
    r1       = first_rd & big_mask;
    r2       = RW'(rd - (cfg.nested_mode ? HDIAL_NEST : HDIAL_FLAT)) & big_mask;
    diff     = RW'(r1 - r2) & big_mask;
    diff_hi  = cfg.nested_mode ? diff[NW-1] : diff[RW-1];
    d_s      = $signed(VW'(diff))
               - (diff_hi ? $signed(cfg.nested_mode ? BIG_NEST : BIG_FLAT) : $signed(VW'(0)));
    bad      = (d_s > $signed(LIM)) || (d_s < -$signed(LIM));
    v_s      = $signed(VW'({r1, 1'b0})) - d_s + $signed(ONE_TICK);
    digit_tw = v_s[F+1 +: CW];
    sum_h    = {1'b0, rd} + HALF_TICK;
    digit_pl = sum_h[F +: CW];
    digit_raw = cfg.twin_mode ? digit_tw : digit_pl;
    digit    = cfg.nested_mode ? {{(CW - GW){1'b0}}, digit_raw[GW-1:0]} : digit_raw;
    code_next = cfg.nested_mode ? {partial, digit[GW-1:0]} : digit;
  end

  always_comb begin
    phase_mask = {cfg.nested_mode & cfg.twin_mode, cfg.nested_mode | cfg.twin_mode};
    phase      = edge_phase & phase_mask;
    dd         = cfg.twin_mode ? phase[1] : phase[0];
    twin_first = cfg.twin_mode && !phase[0];
    nest_first = cfg.nested_mode && !dd;
    emit       = !twin_first && !nest_first;
  end

  always_comb begin
    sum_full = (SW + 1)'(run_sum) + (SW + 1)'(prod);
    if (sum_full[SW] != sum_full[SW-1]) begin
      sum_sat = sum_full[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_full[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slot_offset <= '0;
      edge_phase  <= '0;
      partial     <= '0;
      first_rd    <= '0;
      pair_flag   <= 1'b0;
      run_sum     <= '0;
    end else begin
      if (cmd.start) begin
        slot_offset <= slot_offset + slot_inc;
      end
      if (cmd.digit) begin
        if (twin_first) begin
          first_rd   <= rd & big_mask;
          edge_phase <= phase + 2'd1;
        end else if (nest_first) begin
          partial    <= digit[GW-1:0];
          edge_phase <= phase + 2'd1;
          if (cfg.twin_mode && bad) begin
            pair_flag <= 1'b1;
          end
        end else begin
          partial    <= '0;
          edge_phase <= '0;
          pair_flag  <= 1'b0;
        end
      end
      if (cmd.sum) begin
        run_sum <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      edge_t <= edge_in;
      mult   <= $signed(s_tdata[EW +: MW]);
    end
    if (cmd.offs) begin
      t_off <= edge_t - start_tb - slot_offset;
    end
    if (cmd.start) begin
      neg <= t_off[TB-1];
    end
    if (cmd.read) begin
      rd <= neg ? RW'(~q_lo + RW'(rem == '0)) : q_lo;
    end
    if (cmd.digit && emit) begin
      code_r <= code_next;
      flag_r <= pair_flag | (cfg.twin_mode & bad);
    end
    if (cmd.mul) begin
      prod <= $signed(code_r) * mult;
    end
    if (cmd.sum) begin
      out_code <= code_r;
      out_flag <= flag_r;
      out_sum  <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.sum) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_sum, out_flag, out_code, out_code};

  assign stat.div_done = div_done;
  assign stat.emit     = emit;
  assign stat.out_busy = m_tvalid && !m_tready;

  `PPWD_ASSERT_IMPLY(a_load_out_free, cmd.sum, !(m_tvalid && !m_tready))
  `PPWD_ASSERT_IMPLY(a_valid_from_sum, $rose(m_tvalid), $past(cmd.sum))

endmodule

[rtl/ppwd_ctrl.sv]
// ----------------------------------------------------------------------------
// ppwd_ctrl
// Sequencer stepping one item through offset, divide, digit, multiply, sum.
// ----------------------------------------------------------------------------
module ppwd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            op,
  input  ppwd_pkg::stat_t stat,
  output logic            s_tready,
  output ppwd_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFFS  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DIGIT = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (op == ppwd_pkg::OP_RESTART) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_OFFS;
          end
        end
      end
      S_OFFS: begin
        cmd.offs   = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.digit  = 1'b1;
        state_next = stat.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (!stat.out_busy) begin
          cmd.sum    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/pulse_position_weight_decoder_core.sv]
// ----------------------------------------------------------------------------
// pulse_position_weight_decoder_core
// Sequence: an edge item is loaded on acceptance, then the offset, divider start,
//   divide, read, digit, multiply and sum steps follow; m_tvalid is registered
//   from the sum step. An edge with no result ends after the digit step, and a
//   restart clears in idle. No new item is taken until the last has finished,
//   and the sum step waits for the previous result to leave.
// Reset: synchronous rst clears slot position, phase, sum and output valid;
//   registers return to tick_period 1000, start_time 0, flat, single edges.
// ----------------------------------------------------------------------------
module pulse_position_weight_decoder_core #(
  parameter int TIME_BITS = ppwd_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = ppwd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [47:0] edge_time, [63:48] multiplier
  input  logic [ppwd_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] op
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [11:0] weight_code, [23:12] weight_value, [24] twins_disagreed, [72:25] dot_sum
  output logic [ppwd_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppwd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ppwd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ppwd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int TW = ppwd_pkg::TICK_W;
  localparam int EW = ppwd_pkg::EDGE_W;
  localparam int DW = ppwd_pkg::CFG_DATA_W;
  localparam int IW = ppwd_pkg::REG_IDX_W;

  ppwd_pkg::cfg_t  cfg;
  ppwd_pkg::cmd_t  cmd;
  ppwd_pkg::stat_t stat;

  logic          wr;
  logic [IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ppwd_pkg::CFG_ADDR_W-1 -: IW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period <= ppwd_pkg::TICK_RESET;
      cfg.start_time  <= '0;
      cfg.nested_mode <= 1'b0;
      cfg.twin_mode   <= 1'b0;
    end else if (wr) begin
      unique case (reg_idx)
        ppwd_pkg::REG_TICK:   cfg.tick_period <= pwdata[TW-1:0];
        ppwd_pkg::REG_START:  cfg.start_time  <= pwdata[EW-1:0];
        ppwd_pkg::REG_NESTED: cfg.nested_mode <= pwdata[0];
        ppwd_pkg::REG_TWIN:   cfg.twin_mode   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppwd_pkg::REG_TICK:   prdata = DW'(cfg.tick_period);
      ppwd_pkg::REG_START:  prdata = DW'(cfg.start_time);
      ppwd_pkg::REG_NESTED: prdata = DW'(cfg.nested_mode);
      ppwd_pkg::REG_TWIN:   prdata = DW'(cfg.twin_mode);
      default:              prdata = '0;
    endcase
  end

  ppwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ppwd_datapath #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sim/pulse_position_weight_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// pulse_position_weight_decoder_core_tb
// Self-checking bench for the pulse position weight decoder. Edge timestamps
// are built around chosen dial codes in flat, nested and twin modes, with
// jitter, early and late edges, noise and restarts. A local decoder model
// follows every accepted item, and each result is checked field by field
// against the oldest predicted weight. Register settings change only while
// the block is idle.
// ----------------------------------------------------------------------------
module pulse_position_weight_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC          = ppwd_pkg::FRAC_BITS_DEF;
  localparam int EDGE_W        = ppwd_pkg::EDGE_W;
  localparam int MULT_W        = ppwd_pkg::MULT_W;
  localparam int CODE_W        = ppwd_pkg::CODE_W;
  localparam int SUM_W         = ppwd_pkg::SUM_W;
  localparam int TICK_W        = ppwd_pkg::TICK_W;
  localparam int S_TDATA_W     = ppwd_pkg::S_TDATA_W;
  localparam int M_TDATA_W     = ppwd_pkg::M_TDATA_W;
  localparam int CFG_ADDR_W    = ppwd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W    = ppwd_pkg::CFG_DATA_W;
  localparam int REG_IDX_W     = ppwd_pkg::REG_IDX_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 172;

  typedef struct {
    logic              op;
    logic [EDGE_W-1:0] edge_time;
    logic [MULT_W-1:0] multiplier;
  } edge_item_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] value;
    logic              disagreed;
    logic [SUM_W-1:0]  dot_sum;
  } weight_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pulse_position_weight_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // register mirror
  logic [TICK_W-1:0] cfg_tick   = ppwd_pkg::TICK_RESET;
  logic [EDGE_W-1:0] cfg_start  = '0;
  logic              cfg_nested = 1'b0;
  logic              cfg_twin   = 1'b0;

  // decoder state
  logic [EDGE_W-1:0] slot_pos;
  logic [1:0]        edge_idx;
  logic [CODE_W-1:0] hi_digit;
  logic [19:0]       first_pos;
  logic              pair_bad;
  longint            dot_acc;

  edge_item_t edge_queue[$];
  weight_t    pending_weights[$];
  edge_item_t held_item;
  logic [EDGE_W-1:0] gen_slot;

  int  send_gap = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  int  mismatch_count = 0;
  int  weights_checked = 0;
  int  weights_flagged = 0;
  int  edges_sent = 0;
  int  restarts_sent = 0;

  function automatic logic [19:0] dial_position(logic [EDGE_W-1:0] et, longint tick, longint m);
    logic [EDGE_W-1:0] t;
    logic [EDGE_W-1:0] mag;
    longint q;
    longint rem;
    longint qm;
    t = et - cfg_start - slot_pos;
    mag = t[EDGE_W-1] ? (48'd0 - t) : t;
    q = longint'({16'd0, mag}) / tick;
    rem = longint'({16'd0, mag}) % tick;
    qm = q % m;
    if (t[EDGE_W-1]) begin
      qm = (m - qm + m - ((rem != 0) ? 1 : 0)) % m;
      if (rem != 0) rem = tick - rem;
    end
    return 20'((qm << FRAC) + ((rem << FRAC) / tick));
  endfunction

  function automatic void clear_decoder();
    slot_pos  = '0;
    edge_idx  = '0;
    hi_digit  = '0;
    first_pos = '0;
    pair_bad  = 1'b0;
    dot_acc   = 0;
  endfunction

  function automatic void decode_edge(edge_item_t it);
    longint tick;
    longint m;
    longint big;
    longint epw;
    longint ph;
    longint r;
    longint r1;
    longint r2;
    longint d;
    longint v;
    longint digit;
    longint dd;
    longint code;
    longint wv;
    longint s;
    weight_t w;
    if (it.op == ppwd_pkg::OP_RESTART) begin
      restarts_sent++;
      clear_decoder();
      return;
    end
    edges_sent++;
    tick = (cfg_tick == 0) ? 1 : longint'({48'd0, cfg_tick});
    m = cfg_nested ? 64 : 4096;
    big = m << FRAC;
    r = longint'({44'd0, dial_position(it.edge_time, tick, m)});
    slot_pos = slot_pos + 48'(tick * m);
    epw = (cfg_nested ? 2 : 1) * (cfg_twin ? 2 : 1);
    ph = longint'({62'd0, edge_idx}) & (epw - 1);
    if (cfg_twin) begin
      if ((ph & 1) == 0) begin
        first_pos = 20'(r);
        edge_idx = 2'(ph + 1);
        return;
      end
      r1 = longint'({44'd0, first_pos}) % big;
      r2 = (r + big - ((m / 2) << FRAC)) % big;
      d = (r1 + big - r2) % big;
      if (d >= big / 2) d = d - big;
      if (d > (2 << FRAC) || d < -(2 << FRAC)) pair_bad = 1'b1;
      v = (2 * r1 - d + (1 << FRAC) + 2 * big) % (2 * big);
      digit = (v >> (FRAC + 1)) % m;
    end else begin
      digit = ((r + ((1 << FRAC) >> 1)) >> FRAC) % m;
    end
    dd = cfg_twin ? (ph >> 1) : ph;
    if (cfg_nested && dd == 0) begin
      hi_digit = CODE_W'(digit);
      edge_idx = 2'(ph + 1);
      return;
    end
    code = cfg_nested ? (((longint'({52'd0, hi_digit}) & 63) << 6) | digit) : digit;
    code = code & 12'hFFF;
    wv = (code >= 2048) ? code - 4096 : code;
    s = dot_acc + wv * longint'($signed(it.multiplier));
    if (s > (longint'(1) << 47) - 1) s = (longint'(1) << 47) - 1;
    if (s < -(longint'(1) << 47)) s = -(longint'(1) << 47);
    dot_acc = s;
    w.code = CODE_W'(code);
    w.value = CODE_W'(wv);
    w.disagreed = pair_bad;
    w.dot_sum = SUM_W'(s);
    pending_weights.push_back(w);
    edge_idx = '0;
    hi_digit = '0;
    pair_bad = 1'b0;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
      hold_left = 0;
      clear_decoder();
    end else begin
      if (s_tvalid && s_tready) decode_edge(held_item);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (hold_left > 0) begin
          // stay idle until the block turns ready or the hold runs out
          if (s_tready) begin
            hold_left = 0;
            send_gap = $urandom_range(0, 3);
          end else begin
            hold_left--;
          end
          s_tvalid <= 1'b0;
        end else if (edge_queue.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left = SETTLE_CYCLES;
            s_tvalid <= 1'b0;
          end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
            s_tvalid <= 1'b0;
          end else begin
            held_item = edge_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= held_item.op;
            s_tdata <= {held_item.multiplier, held_item.edge_time};
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    weight_t w;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_weights.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected weight: code %0d dot_sum %0d", m_tdata[11:0],
                     $signed(m_tdata[72:25]));
        end else begin
          w = pending_weights.pop_front();
          weights_checked++;
          if (w.disagreed) weights_flagged++;
          if (m_tdata[11:0] !== w.code || m_tdata[23:12] !== w.value ||
              m_tdata[24] !== w.disagreed || m_tdata[72:25] !== w.dot_sum) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("weight %0d mismatch: code %0d/%0d value %0d/%0d flag %0b/%0b sum %0d/%0d",
                       weights_checked, w.code, m_tdata[11:0], $signed(w.value),
                       $signed(m_tdata[23:12]), w.disagreed, m_tdata[24],
                       $signed(w.dot_sum), $signed(m_tdata[72:25]));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ppwd_pkg::REG_TICK:   cfg_tick = value[TICK_W-1:0];
      ppwd_pkg::REG_START:  cfg_start = value[EDGE_W-1:0];
      ppwd_pkg::REG_NESTED: cfg_nested = value[0];
      ppwd_pkg::REG_TWIN:   cfg_twin = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (edge_queue.size() != 0 || s_tvalid || pending_weights.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic longint tick_now();
    return (cfg_tick == 0) ? 1 : longint'({48'd0, cfg_tick});
  endfunction

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] rand_time();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic void queue_edge(bit absolute, logic [EDGE_W-1:0] offset,
                                     logic [MULT_W-1:0] mult);
    edge_item_t it;
    it.op = ppwd_pkg::OP_EDGE;
    it.edge_time = absolute ? offset : cfg_start + gen_slot + offset;
    it.multiplier = mult;
    edge_queue.push_back(it);
    gen_slot = gen_slot + 48'(tick_now() * (cfg_nested ? 64 : 4096));
  endfunction

  function automatic void queue_restart();
    edge_item_t it;
    it.op = ppwd_pkg::OP_RESTART;
    it.edge_time = rand_time();
    it.multiplier = 16'($urandom_range(0, 65535));
    edge_queue.push_back(it);
    gen_slot = '0;
  endfunction

  // one weight as dial edges, jittered; a broken one pushes twins apart
  function automatic void queue_weight(logic [CODE_W-1:0] code, bit broken);
    longint m;
    longint t;
    longint pos;
    longint jit;
    longint digs[2];
    int nd;
    m = cfg_nested ? 64 : 4096;
    t = tick_now();
    nd = cfg_nested ? 2 : 1;
    digs[0] = cfg_nested ? longint'(code[11:6]) : longint'(code);
    digs[1] = longint'(code[5:0]);
    for (int i = 0; i < nd; i++) begin
      for (int c = 0; c < (cfg_twin ? 2 : 1); c++) begin
        pos = (digs[i] + c * (m / 2)) % m;
        jit = longint'($urandom_range(0, 32'(t))) - t / 2;
        if (broken && $urandom_range(0, 1) == 0)
          jit = jit + ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(2, 6)) * t;
        queue_edge(1'b0, 48'(pos * t + jit), pick_mult());
      end
    end
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2047;
      3: return 12'd2048;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int count;
    int roll;
    logic [TICK_W-1:0] tick_sel;
    logic [EDGE_W-1:0] start_sel;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) calm = 1'b1;
      if (ph > 0) begin
        case (ph)
          1: begin tick_sel = 16'd1; start_sel = 48'hFFFF_FFFF_FFFF; end
          2: begin tick_sel = 16'hFFFF; start_sel = rand_time(); end
          3: begin tick_sel = 16'd0; start_sel = '0; end
          default: begin
            case ($urandom_range(0, 7))
              0: tick_sel = 16'd1;
              1: tick_sel = 16'hFFFF;
              2, 3: tick_sel = 16'($urandom_range(2, 30));
              default: tick_sel = 16'($urandom_range(31, 65535));
            endcase
            start_sel = ($urandom_range(0, 4) == 0) ? 48'hFFFF_FFFF_FFFF : rand_time();
          end
        endcase
        write_reg(ppwd_pkg::REG_TICK, {48'd0, tick_sel});
        write_reg(ppwd_pkg::REG_START, {16'd0, start_sel});
        write_reg(ppwd_pkg::REG_NESTED, {63'd0, (ph == 2 || ph == 3) ? 1'b1 :
                                      (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1))});
        write_reg(ppwd_pkg::REG_TWIN, {63'd0, (ph == 1 || ph == 3) ? 1'b1 :
                                    (ph == 2) ? 1'b0 : 1'($urandom_range(0, 1))});
      end
      gen_slot = slot_pos;
      if (ph == 0) begin
        queue_edge(1'b0, 48'd0, 16'h7FFF);
        queue_edge(1'b0, 48'(4095 * 1000 + 499), 16'h8000);
        queue_edge(1'b0, 48'(2047 * 1000), 16'hFFFF);
        queue_edge(1'b0, 48'(2048 * 1000), 16'h0000);
        queue_edge(1'b0, 48'(5 * 1000 + 500), 16'h0001);
        queue_edge(1'b0, 48'(5 * 1000 + 499), 16'h1234);
        queue_edge(1'b0, 48'hFFFF_FFFF_FFFF, 16'h4000);
        queue_edge(1'b0, 48'(4096 * 1000 + 3000), 16'hC000);
        queue_edge(1'b0, 48'h8000_0000_0000, 16'h7FFF);
        queue_edge(1'b1, 48'hFFFF_FFFF_FFFF, 16'h5555);
        queue_edge(1'b1, 48'h0, 16'hAAAA);
        queue_restart();
        queue_edge(1'b0, 48'd1000, 16'h8000);
        queue_weight(12'd4095, 1'b0);
        queue_weight(12'd2048, 1'b0);
      end
      count = 0;
      while (count < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          queue_restart();
          count++;
        end else if (roll < 12) begin
          queue_edge(1'b1, rand_time(), pick_mult());
          count++;
        end else begin
          queue_weight(pick_code(), $urandom_range(0, 9) == 0);
          count += (cfg_nested ? 2 : 1) * (cfg_twin ? 2 : 1);
        end
      end
      // leave a weight half done across the register change
      queue_edge(1'b0, 48'(longint'($urandom_range(0, 63)) * tick_now()), pick_mult());
    end
    wait_idle();
    $display("covered %0d edges and %0d restarts over %0d register settings",
             edges_sent, restarts_sent, PHASES);
    $display("checked %0d weights, %0d of them with twin disagreement",
             weights_checked, weights_flagged);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
